[rtl/core/rts_pkg.sv]
// shared types and constants for the refinement threshold selector
// no dependencies
package rts_pkg;

    localparam int unsigned MAX_CELLS = 1024;
    localparam int unsigned ADDR_W    = $clog2(MAX_CELLS);
    localparam int unsigned CNT_W     = $clog2(MAX_CELLS + 1);
    localparam int unsigned ERR_W     = 32;
    localparam int unsigned TOT_W     = 42;
    localparam int unsigned FRAC_W    = 16;
    localparam int unsigned OM_W      = FRAC_W + 1;
    localparam int unsigned LIM_W     = OM_W + TOT_W;
    localparam int unsigned SPLIT     = 21;

    localparam logic [ERR_W-1:0] ONE_Q24 = 32'h0100_0000;
    localparam logic [ERR_W-1:0] TWO_Q24 = 32'h0200_0000;
    localparam logic [TOT_W-1:0] TOT_MAX = {TOT_W{1'b1}};

    localparam logic [1:0] CFG_MODE     = 2'd0;
    localparam logic [1:0] CFG_FRACTION = 2'd1;
    localparam logic [1:0] CFG_HALVING  = 2'd2;

    localparam logic [1:0] MODE_FIXED = 2'd0;
    localparam logic [1:0] MODE_BULK  = 2'd1;
    localparam logic [1:0] MODE_MAXF  = 2'd2;

    typedef struct packed {
        logic [ERR_W-1:0] error_value;
        logic             last_cell;
    } t_in_word;

    typedef struct packed {
        logic [ERR_W-1:0] threshold_value;
        logic             refine_needed;
    } t_out_word;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_DECIDE,
        ST_SORT_OUTER,
        ST_SORT_GETV,
        ST_SORT_CMP,
        ST_SORT_PLACE,
        ST_SELECT,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_BULK,
        ST_BULK_ADD,
        ST_PICK_WAIT,
        ST_OUT
    } t_state;

endpackage

[rtl/core/rts_store.sv]
// cell error store: one write port, one read port, registered read data
// depends on rts_pkg
module rts_store (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [rts_pkg::ADDR_W-1:0] i_waddr,
    input  logic [rts_pkg::ERR_W-1:0]  i_wdata,
    input  logic [rts_pkg::ADDR_W-1:0] i_raddr,
    output logic [rts_pkg::ERR_W-1:0]  o_rdata
);
    import rts_pkg::*;

    logic [ERR_W-1:0] r_mem [MAX_CELLS];
    logic [ERR_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/core/refinement_threshold_select.sv]
// top level of the refinement threshold selector
// depends on rts_pkg and rts_store
//
// loads one variable's cell errors (unsigned q8.24) at one word per cycle into a
// 1024-entry store while keeping a saturating total and a maximum. a word marked
// last ends the set and the block goes busy (o_in_ready low) until the result word
// is handed to the output register. with total at most 1.0 the result is 2.0 and
// refine 0; max fraction and halving modes likewise go straight from the decision
// to the output. fixed fraction and bulk modes first run an insertion sort in the
// store, one read and one write per cycle; fixed fraction then reads one entry,
// bulk walks the sorted prefix, reading each cell and then adding it. the single
// store port pair paces the sort and the walk. cells beyond 1024 are dropped. the
// output register lets loading of the next set start while the result word waits.
module refinement_threshold_select (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_addr,
    input  logic [15:0]        i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  rts_pkg::t_in_word  i_in_word,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output rts_pkg::t_out_word o_out_word
);
    import rts_pkg::*;

    // configuration
    logic [1:0]        r_mode;
    logic [FRAC_W-1:0] r_frac;
    logic [4:0]        r_halve;

    // accumulators for the set being loaded
    logic [TOT_W-1:0] r_total, n_total;
    logic [ERR_W-1:0] r_max,   n_max;
    logic [CNT_W-1:0] r_count, n_count;

    // working copy of the finished set
    t_state           r_state, n_state;
    logic [TOT_W-1:0] r_wtot,  n_wtot;
    logic [ERR_W-1:0] r_wmax,  n_wmax;
    logic [CNT_W-1:0] r_n,     n_n;
    logic [CNT_W-1:0] r_a,     n_a;      // outer sort index, also bulk walk index
    logic [CNT_W-1:0] r_b,     n_b;      // inner sort index
    logic [ERR_W-1:0] r_v,     n_v;      // value being inserted
    logic [TOT_W-1:0] r_acc,   n_acc;
    logic [OM_W+SPLIT-1:0] r_lim_lo, n_lim_lo;
    logic [LIM_W-1:0] r_lim,   n_lim;
    logic [ERR_W-1:0] r_result, n_result;
    logic             r_flag,  n_flag;

    // output register
    logic             r_out_valid, n_out_valid;
    t_out_word        r_out_word,  n_out_word;

    // store ports
    logic              we;
    logic [ADDR_W-1:0] waddr, raddr;
    logic [ERR_W-1:0]  wdata, rdata;

    logic              in_acc;
    logic [TOT_W:0]    sum_wide;
    logic [OM_W-1:0]   one_minus;
    logic [OM_W+CNT_W-1:0] k_prod;
    logic [CNT_W-1:0]  k_idx;
    logic [ERR_W+FRAC_W-1:0] maxf_prod;
    logic [CNT_W-1:0]  a_dec, b_dec, b_dec2;

    rts_store u_store (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    assign o_in_ready  = (r_state == ST_LOAD);
    assign in_acc      = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    assign one_minus = (OM_W)'(17'h1_0000) - {1'b0, r_frac};
    assign sum_wide  = {1'b0, r_total} + {{(TOT_W + 1 - ERR_W){1'b0}}, i_in_word.error_value};
    assign k_prod    = one_minus * r_n;
    assign maxf_prod = r_frac * r_wmax;
    assign a_dec     = r_a - CNT_W'(1);
    assign b_dec     = r_b - CNT_W'(1);
    assign b_dec2    = r_b - CNT_W'(2);

    // fixed fraction rank, clamped to the last stored cell
    always_comb begin
        if (k_prod[OM_W+CNT_W-1:FRAC_W] > {1'b0, a_dec}) begin
            k_idx = a_dec;
        end else begin
            k_idx = k_prod[FRAC_W+CNT_W-1:FRAC_W];
        end
    end

    always_comb begin
        n_state     = r_state;
        n_total     = r_total;
        n_max       = r_max;
        n_count     = r_count;
        n_wtot      = r_wtot;
        n_wmax      = r_wmax;
        n_n         = r_n;
        n_a         = r_a;
        n_b         = r_b;
        n_v         = r_v;
        n_acc       = r_acc;
        n_lim_lo    = r_lim_lo;
        n_lim       = r_lim;
        n_result    = r_result;
        n_flag      = r_flag;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out_word  = r_out_word;
        we          = 1'b0;
        waddr       = r_count[ADDR_W-1:0];
        wdata       = i_in_word.error_value;
        raddr       = r_a[ADDR_W-1:0];

        case (r_state)
            ST_LOAD: begin
                if (in_acc) begin
                    logic [TOT_W-1:0] tot_upd;
                    logic [ERR_W-1:0] max_upd;
                    logic [CNT_W-1:0] cnt_upd;
                    tot_upd = r_total;
                    max_upd = r_max;
                    cnt_upd = r_count;
                    // a full store drops the word
                    if (r_count < CNT_W'(MAX_CELLS)) begin
                        we      = 1'b1;
                        cnt_upd = r_count + CNT_W'(1);
                        tot_upd = sum_wide[TOT_W] ? TOT_MAX : sum_wide[TOT_W-1:0];
                        if (i_in_word.error_value > r_max) begin
                            max_upd = i_in_word.error_value;
                        end
                    end
                    if (i_in_word.last_cell) begin
                        n_wtot  = tot_upd;
                        n_wmax  = max_upd;
                        n_n     = cnt_upd;
                        n_total = '0;
                        n_max   = '0;
                        n_count = '0;
                        n_state = ST_DECIDE;
                    end else begin
                        n_total = tot_upd;
                        n_max   = max_upd;
                        n_count = cnt_upd;
                    end
                end
            end
            ST_DECIDE: begin
                n_a = CNT_W'(1);
                if (r_wtot <= {{(TOT_W - ERR_W){1'b0}}, ONE_Q24}) begin
                    n_result = TWO_Q24;
                    n_flag   = 1'b0;
                    n_state  = ST_OUT;
                end else begin
                    n_flag = 1'b1;
                    case (r_mode)
                        MODE_FIXED, MODE_BULK: n_state = ST_SORT_OUTER;
                        MODE_MAXF: begin
                            n_result = maxf_prod[ERR_W+FRAC_W-1:FRAC_W];
                            n_state  = ST_OUT;
                        end
                        default: begin
                            n_result = r_wmax >> r_halve;
                            n_state  = ST_OUT;
                        end
                    endcase
                end
            end
            ST_SORT_OUTER: begin
                if (r_a < r_n) begin
                    raddr   = r_a[ADDR_W-1:0];
                    n_state = ST_SORT_GETV;
                end else begin
                    n_state = (r_mode == MODE_BULK) ? ST_MUL_LO : ST_SELECT;
                end
            end
            ST_SORT_GETV: begin
                n_v     = rdata;
                n_b     = r_a;
                raddr   = a_dec[ADDR_W-1:0];
                n_state = ST_SORT_CMP;
            end
            ST_SORT_CMP: begin
                // rdata holds store[b-1]; reads and writes never hit the same entry
                we    = 1'b1;
                waddr = r_b[ADDR_W-1:0];
                if (rdata > r_v) begin
                    wdata = rdata;
                    n_b   = b_dec;
                    raddr = b_dec2[ADDR_W-1:0];
                    if (b_dec == '0) begin
                        n_state = ST_SORT_PLACE;
                    end
                end else begin
                    wdata   = r_v;
                    n_a     = r_a + CNT_W'(1);
                    n_state = ST_SORT_OUTER;
                end
            end
            ST_SORT_PLACE: begin
                we      = 1'b1;
                waddr   = r_b[ADDR_W-1:0];
                wdata   = r_v;
                n_a     = r_a + CNT_W'(1);
                n_state = ST_SORT_OUTER;
            end
            ST_SELECT: begin
                // r_a equals n here, so a_dec is n-1
                raddr   = k_idx[ADDR_W-1:0];
                n_state = ST_PICK_WAIT;
            end
            ST_MUL_LO: begin
                n_lim_lo = one_minus * r_wtot[SPLIT-1:0];
                n_state  = ST_MUL_HI;
            end
            ST_MUL_HI: begin
                logic [OM_W+TOT_W-SPLIT-1:0] hi_prod;
                hi_prod = one_minus * r_wtot[TOT_W-1:SPLIT];
                n_lim   = {hi_prod, {SPLIT{1'b0}}} + LIM_W'(r_lim_lo);
                n_a     = '0;
                n_acc   = '0;
                n_state = ST_BULK;
            end
            ST_BULK: begin
                raddr = r_a[ADDR_W-1:0];
                if ((r_a < r_n - CNT_W'(1)) &&
                    ({1'b0, r_acc, {FRAC_W{1'b0}}} < r_lim)) begin
                    n_state = ST_BULK_ADD;
                end else begin
                    n_state = ST_PICK_WAIT;
                end
            end
            ST_BULK_ADD: begin
                n_acc   = r_acc + {{(TOT_W - ERR_W){1'b0}}, rdata};
                n_a     = r_a + CNT_W'(1);
                n_state = ST_BULK;
            end
            ST_PICK_WAIT: begin
                n_result = rdata;
                n_state  = ST_OUT;
            end
            ST_OUT: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid                = 1'b1;
                    n_out_word.threshold_value = r_result;
                    n_out_word.refine_needed   = r_flag;
                    n_state                    = ST_LOAD;
                end
            end
            default: n_state = ST_LOAD;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_LOAD;
            r_total     <= '0;
            r_max       <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
            r_mode      <= MODE_FIXED;
            r_frac      <= 16'h8000;
            r_halve     <= 5'd1;
        end else begin
            r_state     <= n_state;
            r_total     <= n_total;
            r_max       <= n_max;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    CFG_MODE:     r_mode  <= i_cfg_data[1:0];
                    CFG_FRACTION: r_frac  <= i_cfg_data;
                    CFG_HALVING:  r_halve <= i_cfg_data[4:0];
                    default: ;
                endcase
            end
        end
    end

    // payload and working registers
    always_ff @(posedge i_clk) begin
        r_wtot     <= n_wtot;
        r_wmax     <= n_wmax;
        r_n        <= n_n;
        r_a        <= n_a;
        r_b        <= n_b;
        r_v        <= n_v;
        r_acc      <= n_acc;
        r_lim_lo   <= n_lim_lo;
        r_lim      <= n_lim;
        r_result   <= n_result;
        r_flag     <= n_flag;
        r_out_word <= n_out_word;
    end

    // store fill never passes its depth
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_CELLS))
        else $error("cell count beyond store depth");

    // sort inner index stays within the set
    a_sort_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SORT_CMP) |-> (r_b != '0 && r_b < r_n))
        else $error("sort inner index out of range");

    // a result word leaves busy mode straight back to loading
    a_out_return: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_OUT && (!r_out_valid || i_out_ready)) |=>
        (r_out_valid && r_state == ST_LOAD))
        else $error("result word not loaded");

    // a last word always leaves loading
    a_last_leaves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_in_word.last_cell) |=> (r_state == ST_DECIDE && r_count == '0))
        else $error("set not closed on last word");

endmodule
